// ===== src/qai_pkg.sv =====
package qai_pkg;

  localparam int unsigned QuatFracBits = 30;

  // register indexes on the configuration port
  localparam logic [1:0] RegInitW = 2'd0;
  localparam logic [1:0] RegInitX = 2'd1;
  localparam logic [1:0] RegInitY = 2'd2;
  localparam logic [1:0] RegInitZ = 2'd3;

  typedef struct packed {
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic        [31:0] time_step;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] q_w;
    logic signed [31:0] q_x;
    logic signed [31:0] q_y;
    logic signed [31:0] q_z;
    logic               degenerate;
  } out_item_t;

endpackage

// ===== src/qai_mul.sv =====
module qai_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic               done_o,
  output logic signed [64:0] prod_o
);
  import qai_pkg::*;

  logic [31:0] ma_q;
  logic [63:0] acc_q;
  logic        neg_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] abs_a;
  logic [32:0] abs_b;
  logic [32:0] sum;

  assign abs_a = a_i[32] ? 33'(-a_i) : a_i;
  assign abs_b = b_i[32] ? 33'(-b_i) : b_i;
  // one multiplier bit a cycle, partial sum enters at the top
  assign sum   = {1'b0, acc_q[63:32]} + (acc_q[0] ? {1'b0, ma_q} : 33'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= abs_a[31:0];
      acc_q <= {32'd0, abs_b[31:0]};
      neg_q <= a_i[32] ^ b_i[32];
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[31:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});

endmodule

// ===== src/quaternion_attitude_integrator.sv =====
// channel   direction  handshake              payload
// in        input      in_valid_i/in_ready_o  in_data_i  (rates, time step, restart)
// out       output     out_valid_o/out_ready_i out_data_o (quaternion, degenerate)
// cfg       input      apb psel/penable       init_w..init_z at 0x0..0xc
//
// a single bit-serial 32x32 multiplier does the 19 products of an integrate item
// (or the 4 of a restart) one after another, then a 32-step square root and,
// unless the length is zero, four 31-step restoring divisions follow.
// one item at a time; in_ready_o is high only while no item is in work.
// a finished result waits in the output register; a stalled output holds the
// block before its final write, the input side accepts again once it is taken.
// reset loads the identity attitude and the initial quaternion registers.
module quaternion_attitude_integrator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qai_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qai_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import qai_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HMUL  = 4'd1;
  localparam logic [3:0] S_PMUL  = 4'd2;
  localparam logic [3:0] S_MAG   = 4'd3;
  localparam logic [3:0] S_SHIFT = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]         state_q;
  logic [3:0]         op_q;
  logic               wait_q;
  logic               out_valid_q;
  logic signed [31:0] att_q [4];
  logic signed [31:0] init_q [4];

  in_item_t           item_q;
  logic signed [36:0] v_q [4];
  logic signed [31:0] h_q [3];
  logic [35:0]        mag_q [4];
  logic [3:0]         sgn_q;
  logic [63:0]        sum_q;
  logic [63:0]        r_q;
  logic [63:0]        b_q;
  logic [31:0]        rem_q;
  logic [30:0]        qsh_q;
  logic [4:0]         dcnt_q;
  logic               degen_q;
  out_item_t          out_q;

  logic               mul_start;
  logic               mul_done;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] prod;
  logic signed [64:0] hs;
  logic signed [31:0] hsat;
  logic signed [36:0] pterm;
  logic [1:0]         hi;
  logic [1:0]         ai;
  logic [1:0]         tg;
  logic               ng;
  logic               mag_ovf;
  logic [64:0]        sq_t;
  logic [61:0]        num;
  logic [32:0]        div_t;
  logic               div_ge;
  logic [31:0]        len;
  logic               out_load;
  logic               cfg_wr;

  assign in_ready_o = (state_q == S_IDLE);
  assign mul_start  = ((state_q == S_HMUL) || (state_q == S_PMUL) || (state_q == S_SQ))
                      && !wait_q;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign cfg_wr     = psel && penable && pwrite;
  assign len        = r_q[31:0];

  // product schedule: component index 0..3 is w,x,y,z; half angle 0..2 is x,y,z
  always_comb begin
    case (op_q)
      4'd0:    begin hi = 2'd0; ai = 2'd1; tg = 2'd0; ng = 1'b1; end
      4'd1:    begin hi = 2'd1; ai = 2'd2; tg = 2'd0; ng = 1'b1; end
      4'd2:    begin hi = 2'd2; ai = 2'd3; tg = 2'd0; ng = 1'b1; end
      4'd3:    begin hi = 2'd0; ai = 2'd0; tg = 2'd1; ng = 1'b0; end
      4'd4:    begin hi = 2'd1; ai = 2'd3; tg = 2'd1; ng = 1'b0; end
      4'd5:    begin hi = 2'd2; ai = 2'd2; tg = 2'd1; ng = 1'b1; end
      4'd6:    begin hi = 2'd1; ai = 2'd0; tg = 2'd2; ng = 1'b0; end
      4'd7:    begin hi = 2'd2; ai = 2'd1; tg = 2'd2; ng = 1'b0; end
      4'd8:    begin hi = 2'd0; ai = 2'd3; tg = 2'd2; ng = 1'b1; end
      4'd9:    begin hi = 2'd2; ai = 2'd0; tg = 2'd3; ng = 1'b0; end
      4'd10:   begin hi = 2'd0; ai = 2'd2; tg = 2'd3; ng = 1'b0; end
      4'd11:   begin hi = 2'd1; ai = 2'd1; tg = 2'd3; ng = 1'b1; end
      default: begin hi = 2'd0; ai = 2'd1; tg = 2'd0; ng = 1'b1; end
    endcase
  end

  always_comb begin
    case (state_q)
      S_HMUL: begin
        case (op_q[1:0])
          2'd0:    mul_a = {item_q.rate_x[31], item_q.rate_x};
          2'd1:    mul_a = {item_q.rate_y[31], item_q.rate_y};
          default: mul_a = {item_q.rate_z[31], item_q.rate_z};
        endcase
        mul_b = {1'b0, item_q.time_step};
      end
      S_PMUL: begin
        mul_a = {h_q[hi][31], h_q[hi]};
        mul_b = {att_q[ai][31], att_q[ai]};
      end
      S_SQ: begin
        mul_a = {2'b00, mag_q[op_q[1:0]][30:0]};
        mul_b = {2'b00, mag_q[op_q[1:0]][30:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  qai_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // half angle, saturated to the q2.30 range
  assign hs    = prod >>> 11;
  assign hsat  = ((&hs[64:31]) || !(|hs[64:31])) ? hs[31:0]
               : (hs[64] ? 32'sh8000_0000 : 32'sh7fff_ffff);
  assign pterm = 37'(prod >>> QuatFracBits);

  assign mag_ovf = (|mag_q[0][35:31]) || (|mag_q[1][35:31]) ||
                   (|mag_q[2][35:31]) || (|mag_q[3][35:31]);

  assign sq_t   = {1'b0, r_q} + {1'b0, b_q};
  assign num    = (62'(mag_q[op_q[1:0]][30:0]) << QuatFracBits) + 62'(len >> 1);
  assign div_t  = {rem_q, qsh_q[30]};
  assign div_ge = (div_t >= {1'b0, len});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      att_q[0]    <= 32'sd1 <<< QuatFracBits;
      att_q[1]    <= '0;
      att_q[2]    <= '0;
      att_q[3]    <= '0;
      init_q[0]   <= 32'sd1073741824;
      init_q[1]   <= '0;
      init_q[2]   <= '0;
      init_q[3]   <= '0;
    end else begin
      if (cfg_wr) begin
        init_q[paddr[3:2]] <= pwdata;
      end
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= in_data_i.restart ? S_MAG : S_HMUL;
            op_q    <= '0;
            wait_q  <= 1'b0;
          end
        end
        S_HMUL, S_PMUL, S_SQ: begin
          if (mul_start) begin
            wait_q <= 1'b1;
          end else if (mul_done) begin
            wait_q <= 1'b0;
            if (state_q == S_HMUL && op_q == 4'd2) begin
              op_q    <= '0;
              state_q <= S_PMUL;
            end else if (state_q == S_PMUL && op_q == 4'd11) begin
              op_q    <= '0;
              state_q <= S_MAG;
            end else if (state_q == S_SQ && op_q == 4'd3) begin
              op_q    <= '0;
              state_q <= S_SQRT;
            end else begin
              op_q <= op_q + 4'd1;
            end
          end
        end
        S_MAG: state_q <= S_SHIFT;
        S_SHIFT: begin
          if (!mag_ovf) begin
            op_q    <= '0;
            wait_q  <= 1'b0;
            state_q <= S_SQ;
          end
        end
        S_SQRT: begin
          if (b_q[0]) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          op_q    <= '0;
          wait_q  <= 1'b0;
          state_q <= (len == 32'd0) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (dcnt_q == 5'd31) begin
            att_q[op_q[1:0]] <= sgn_q[op_q[1:0]] ? -$signed({1'b0, qsh_q})
                                                  : $signed({1'b0, qsh_q});
            wait_q <= 1'b0;
            if (op_q == 4'd3) begin
              state_q <= S_OUT;
            end else begin
              op_q <= op_q + 4'd1;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_q <= in_data_i;
          for (int i = 0; i < 4; i++) begin
            v_q[i] <= in_data_i.restart ? {{5{init_q[i][31]}}, init_q[i]}
                                        : {{5{att_q[i][31]}}, att_q[i]};
          end
        end
      end
      S_HMUL: begin
        if (mul_done) begin
          h_q[op_q[1:0]] <= hsat;
        end
      end
      S_PMUL: begin
        if (mul_done) begin
          v_q[tg] <= ng ? v_q[tg] - pterm : v_q[tg] + pterm;
        end
      end
      S_MAG: begin
        for (int i = 0; i < 4; i++) begin
          sgn_q[i] <= v_q[i][36];
          mag_q[i] <= v_q[i][36] ? 36'(-v_q[i]) : v_q[i][35:0];
        end
      end
      S_SHIFT: begin
        if (mag_ovf) begin
          for (int i = 0; i < 4; i++) begin
            mag_q[i] <= mag_q[i] >> 1;
          end
        end else begin
          sum_q <= '0;
          r_q   <= '0;
          b_q   <= 64'd1 << 62;
        end
      end
      S_SQ: begin
        if (mul_done) begin
          sum_q <= sum_q + prod[63:0];
        end
      end
      S_SQRT: begin
        if ({1'b0, sum_q} >= sq_t) begin
          sum_q <= sum_q - sq_t[63:0];
          r_q   <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q <= b_q >> 2;
      end
      S_CHK: degen_q <= (len == 32'd0);
      S_DIV: begin
        if (!wait_q) begin
          rem_q  <= {1'b0, num[61:31]};
          qsh_q  <= num[30:0];
          dcnt_q <= '0;
        end else if (dcnt_q != 5'd31) begin
          rem_q  <= div_ge ? 32'(div_t - {1'b0, len}) : div_t[31:0];
          qsh_q  <= {qsh_q[29:0], div_ge};
          dcnt_q <= dcnt_q + 5'd1;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_q.q_w        <= att_q[0];
          out_q.q_x        <= att_q[1];
          out_q.q_y        <= att_q[2];
          out_q.q_z        <= att_q[3];
          out_q.degenerate <= degen_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (paddr[3:2])
      RegInitW: prdata = init_q[0];
      RegInitX: prdata = init_q[1];
      RegInitY: prdata = init_q[2];
      RegInitZ: prdata = init_q[3];
      default:  prdata = init_q[0];
    endcase
  end

  assign pready      = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (len != 32'd0))
    else $error("division entered with zero length");

  a_sq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQ) |-> !mag_ovf)
    else $error("magnitude above 31 bits while squaring");

  a_mul_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> wait_q)
    else $error("multiplier result with no product pending");

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.degenerate) |->
      (out_q.q_w <= (32'sd1 <<< QuatFracBits)) && (out_q.q_w >= -(32'sd1 <<< QuatFracBits)))
    else $error("normalized component beyond unit range");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import qai_pkg::*;

  localparam int unsigned NumRandom = 1130;
  localparam longint unsigned CycleLimit = 64'd6_000_000;
  localparam int unsigned LongHold = 3000;

  // attitude predictor and store of expected quaternions
  class attitude_board;
    longint att[4];
    longint init_q[4];
    out_item_t pending_q[$];
    int unsigned errors;

    function new();
      att = '{longint'(1) << QuatFracBits, 0, 0, 0};
      init_q = '{longint'(1) << QuatFracBits, 0, 0, 0};
      errors = 0;
    endfunction

    function void set_init(int idx, logic [31:0] val);
      init_q[idx] = longint'(signed'(val));
    endfunction

    function longint sat32(longint v);
      if (v > 64'sh7fffffff) return 64'sh7fffffff;
      if (v < -64'sh80000000) return -64'sh80000000;
      return v;
    endfunction

    function longint mul_q30(longint a, longint b);
      return (a * b) >>> 30;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      longint v[4], h[3], dt;
      longint unsigned mag[4], big, total, len, q;
      int s;
      out_item_t exp_item;
      if (it.restart) begin
        v = init_q;
      end else begin
        dt = longint'({32'd0, it.time_step});
        h[0] = sat32((longint'(it.rate_x) * dt) >>> 11);
        h[1] = sat32((longint'(it.rate_y) * dt) >>> 11);
        h[2] = sat32((longint'(it.rate_z) * dt) >>> 11);
        v[0] = att[0] - mul_q30(h[0], att[1]) - mul_q30(h[1], att[2])
               - mul_q30(h[2], att[3]);
        v[1] = att[1] + mul_q30(h[0], att[0]) + mul_q30(h[1], att[3])
               - mul_q30(h[2], att[2]);
        v[2] = att[2] + mul_q30(h[1], att[0]) + mul_q30(h[2], att[1])
               - mul_q30(h[0], att[3]);
        v[3] = att[3] + mul_q30(h[2], att[0]) + mul_q30(h[0], att[2])
               - mul_q30(h[1], att[1]);
      end
      big = 0;
      for (int i = 0; i < 4; i++) begin
        mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
        if (mag[i] > big) big = mag[i];
      end
      s = 0;
      while (s < 63 && (big >> s) > 64'h7fffffff) s++;
      total = 0;
      for (int i = 0; i < 4; i++) begin
        mag[i] >>= s;
        total += mag[i] * mag[i];
      end
      len = int_sqrt(total);
      if (len != 0) begin
        for (int i = 0; i < 4; i++) begin
          q = ((mag[i] << QuatFracBits) + (len >> 1)) / len;
          att[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
      end
      exp_item.q_w = att[0][31:0];
      exp_item.q_x = att[1][31:0];
      exp_item.q_y = att[2][31:0];
      exp_item.q_z = att[3][31:0];
      exp_item.degenerate = (len == 0);
      pending_q.push_back(exp_item);
    endfunction

    function void check(out_item_t got);
      out_item_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: %p", got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.q_w !== e.q_w) begin
        $error("q_w: expected %0d, actual %0d", e.q_w, got.q_w);
        errors++;
      end
      if (got.q_x !== e.q_x) begin
        $error("q_x: expected %0d, actual %0d", e.q_x, got.q_x);
        errors++;
      end
      if (got.q_y !== e.q_y) begin
        $error("q_y: expected %0d, actual %0d", e.q_y, got.q_y);
        errors++;
      end
      if (got.q_z !== e.q_z) begin
        $error("q_z: expected %0d, actual %0d", e.q_z, got.q_z);
        errors++;
      end
      if (got.degenerate !== e.degenerate) begin
        $error("degenerate: expected %0b, actual %0b", e.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_item_t in_data_i;
  out_item_t out_data_o;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  attitude_board board;
  longint unsigned cycles = 0;
  bit calm;
  int unsigned hold_reqs, holds_done, hold_left;

  quaternion_attitude_integrator u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left <= 0;
      holds_done <= 0;
    end else begin
      if (out_valid_o && out_ready_i) board.check(out_data_o);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (holds_done < hold_reqs) begin
        holds_done <= holds_done + 1;
        hold_left <= LongHold;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  // leaves psel high; set_init_all closes the last access
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    board.set_init(idx, val);
  endtask

  task automatic set_init_all(logic [31:0] w, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z);
    cfg_write(RegInitW, w);
    cfg_write(RegInitX, x);
    cfg_write(RegInitY, y);
    cfg_write(RegInitZ, z);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send(in_item_t it);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_input(it);
  endtask

  function automatic in_item_t make_item(logic [31:0] rx, logic [31:0] ry,
                                         logic [31:0] rz, logic [31:0] dt,
                                         logic rs);
    in_item_t it;
    it.rate_x = rx;
    it.rate_y = ry;
    it.rate_z = rz;
    it.time_step = dt;
    it.restart = rs;
    return it;
  endfunction

  function automatic logic [31:0] small_rate();
    return 32'($signed($urandom) >>> $urandom_range(31, 10));
  endfunction

  function automatic in_item_t random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6)
      return make_item($urandom, $urandom, $urandom, $urandom, 1'b1);
    if (pick < 18)
      return make_item($urandom, $urandom, $urandom, $urandom, 1'b0);
    return make_item(small_rate(), small_rate(), small_rate(),
                     $urandom >> $urandom_range(31, 6), 1'b0);
  endfunction

  initial begin
    board = new();
    calm = 1'b0;
    hold_reqs = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset registers, rate extremes, saturating half angles
    send(make_item(32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
    send(make_item(32'h0, 32'h0, 32'h0, 32'hffffffff, 1'b0));
    send(make_item(32'h0001_0000, 32'h0, 32'h0, 32'h0010_0000, 1'b0));
    send(make_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 1'b0));
    send(make_item(32'h80000000, 32'h80000000, 32'h80000000, 32'hffffffff, 1'b0));
    send(make_item(32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 1'b0));
    send(make_item(32'hffffffff, 32'h1, 32'hffffffff, 32'h8000_0000, 1'b0));
    send(make_item(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1));
    drain();
    // all-zero initial quaternion: restart is degenerate
    set_init_all(32'h0, 32'h0, 32'h0, 32'h0);
    send(make_item(32'h1234, 32'h0, 32'h0, 32'h0100_0000, 1'b1));
    send(make_item(32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0001_0000, 1'b0));
    drain();
    set_init_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send(make_item(32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
    send(make_item(32'h0, 32'h0004_0000, 32'h0, 32'h0080_0000, 1'b0));
    drain();
    set_init_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send(make_item(32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
    drain();
    set_init_all(32'h0, 32'h0, 32'h0, 32'h1);
    send(make_item(32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
    send(make_item(32'hfffe_0000, 32'h0003_0000, 32'h0001_8000, 32'h0040_0000, 1'b0));
    drain();
    set_init_all(32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff);
    send(make_item(32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
    drain();

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 250 == 0) begin
        drain();
        set_init_all($urandom, $urandom, $urandom, $urandom);
      end
      calm = (n >= 400 && n < 520);
      if (n == 700) hold_reqs = hold_reqs + 1;
      if (n == 900) drain();
      send(random_item());
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
